/* rtl/two_class_age_ordered_fifo_macros.svh */
// Assertion macros for the port-level checker file of this block.
// Each use names a label, a property expression and a message string.
// clk and arst_n are taken from the scope where the macro is used.
`ifndef TWO_CLASS_AGE_ORDERED_FIFO_MACROS_SVH
`define TWO_CLASS_AGE_ORDERED_FIFO_MACROS_SVH

// Checked only while out of reset.
`define TCAF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCAF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tcaf_pkg.sv */
// ----------------------------------------------------------------------------
// tcaf_pkg
// Shared sizes, codes and types for the two-class age-ordered FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcaf_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int HANDLE_WIDTH = 16;
	localparam int STAMP_WIDTH  = 16;
	localparam int PTR_WIDTH    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_ENQ     = 2'd0,
		KIND_DEQ_ANY = 2'd1,
		KIND_DEQ_A   = 2'd2,
		KIND_DEQ_B   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic CLASS_A = 1'b0;
	localparam logic CLASS_B = 1'b1;

	typedef struct packed {
		logic [HANDLE_WIDTH-1:0] handle;
		logic [STAMP_WIDTH-1:0]  stamp;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// Circular pointer advance that also works for depths that are not a power of two.
	function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p);
		return (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

/* rtl/tcaf_queue.sv */
// ----------------------------------------------------------------------------
// tcaf_queue
// One class queue: a circular store of handle and stamp entries with head,
// tail and fill count. The head entry is always presented for reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcaf_queue import tcaf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_ctl_t  ctl,
	input  entry_t      wr_entry,
	output queue_stat_t stat,
	output entry_t      head_entry
);

	entry_t                 mem_q [QUEUE_DEPTH];
	logic [PTR_WIDTH-1:0]   head_q;
	logic [PTR_WIDTH-1:0]   tail_q;
	logic [CNT_WIDTH-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.push) begin
			tail_q  <= next_ptr(tail_q);
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			head_q  <= next_ptr(head_q);
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_q] <= wr_entry;
		end
	end

	assign head_entry = mem_q[head_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_WIDTH'(QUEUE_DEPTH));

endmodule

/* rtl/two_class_age_ordered_fifo.sv */
// ----------------------------------------------------------------------------
// two_class_age_ordered_fifo
// Two class queues sharing one arrival stamp counter. A request either
// enqueues a handle into the queue of its class, or dequeues the oldest item
// of class A, of class B, or of either class by wrap-safe stamp comparison.
// Every request gives exactly one result with a status. One request is taken
// per cycle, and results come out at one per cycle while the result side
// does not stall. A request is held in the request register, and the queue
// update is done in the single pass from there into the result register,
// from which its result is offered. A stalled result holds the request
// register, and the request side then stalls. Pushing to a full queue or
// popping an empty one reports a status and changes nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_class_age_ordered_fifo import tcaf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              kind,
	input  logic                    item_class,
	input  logic [HANDLE_WIDTH-1:0] item_handle,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [1:0]              status,
	output logic                    out_class,
	output logic [HANDLE_WIDTH-1:0] out_handle,
	output logic [STAMP_WIDTH-1:0]  out_stamp
);

	// Request register.
	logic                    valid_s1;
	kind_t                   kind_s1;
	logic                    class_s1;
	logic [HANDLE_WIDTH-1:0] handle_s1;

	// Result register.
	logic                    res_valid_q;
	status_t                 res_status_q;
	logic                    res_class_q;
	logic [HANDLE_WIDTH-1:0] res_handle_q;
	logic [STAMP_WIDTH-1:0]  res_stamp_q;

	logic [STAMP_WIDTH-1:0]  stamp_q;

	logic                    advance;
	queue_ctl_t              ctl_a;
	queue_ctl_t              ctl_b;
	queue_stat_t             stat_a;
	queue_stat_t             stat_b;
	entry_t                  head_a;
	entry_t                  head_b;
	entry_t                  wr_entry;
	logic                    enq_ok;
	logic [STAMP_WIDTH-1:0]  stamp_diff;
	logic                    a_older;

	status_t                 nxt_status;
	logic                    nxt_class;
	logic [HANDLE_WIDTH-1:0] nxt_handle;
	logic [STAMP_WIDTH-1:0]  nxt_stamp;

	assign advance   = valid_s1 && (!res_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			kind_s1   <= kind_t'(kind);
			class_s1  <= item_class;
			handle_s1 <= item_handle;
		end
	end

	assign wr_entry.handle = handle_s1;
	assign wr_entry.stamp  = stamp_q;

	tcaf_queue u_queue_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_a),
		.wr_entry   (wr_entry),
		.stat       (stat_a),
		.head_entry (head_a)
	);

	tcaf_queue u_queue_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_b),
		.wr_entry   (wr_entry),
		.stat       (stat_b),
		.head_entry (head_b)
	);

	// A is older when the modular difference of the head stamps is negative; ties go to B.
	assign stamp_diff = head_a.stamp - head_b.stamp;
	assign a_older    = stamp_diff[STAMP_WIDTH-1];

	always_comb begin
		ctl_a      = '0;
		ctl_b      = '0;
		enq_ok     = 1'b0;
		nxt_status = ST_DONE;
		nxt_class  = CLASS_A;
		nxt_handle = '0;
		nxt_stamp  = '0;
		case (kind_s1)
			KIND_ENQ: begin
				nxt_class  = class_s1;
				nxt_handle = handle_s1;
				nxt_stamp  = stamp_q;
				if ((class_s1 == CLASS_B) ? stat_b.full : stat_a.full) begin
					nxt_status = ST_FULL;
				end else begin
					enq_ok     = 1'b1;
					ctl_a.push = (class_s1 == CLASS_A);
					ctl_b.push = (class_s1 == CLASS_B);
				end
			end
			KIND_DEQ_A: begin
				if (stat_a.empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					ctl_a.pop  = 1'b1;
					nxt_handle = head_a.handle;
					nxt_stamp  = head_a.stamp;
				end
			end
			KIND_DEQ_B: begin
				nxt_class = CLASS_B;
				if (stat_b.empty) begin
					nxt_status = ST_EMPTY;
				end else begin
					ctl_b.pop  = 1'b1;
					nxt_handle = head_b.handle;
					nxt_stamp  = head_b.stamp;
				end
			end
			KIND_DEQ_ANY: begin
				if (stat_a.empty && stat_b.empty) begin
					nxt_status = ST_EMPTY;
				end else if (!stat_a.empty && (stat_b.empty || a_older)) begin
					ctl_a.pop  = 1'b1;
					nxt_handle = head_a.handle;
					nxt_stamp  = head_a.stamp;
				end else begin
					ctl_b.pop  = 1'b1;
					nxt_class  = CLASS_B;
					nxt_handle = head_b.handle;
					nxt_stamp  = head_b.stamp;
				end
			end
			default: begin
				nxt_status = ST_DONE;
			end
		endcase
		// Queue state only changes when the request actually moves into the result register.
		if (!advance) begin
			ctl_a  = '0;
			ctl_b  = '0;
			enq_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (enq_ok) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_status_q <= nxt_status;
			res_class_q  <= nxt_class;
			res_handle_q <= nxt_handle;
			res_stamp_q  <= nxt_stamp;
		end
	end

	assign rsp_valid  = res_valid_q;
	assign status     = res_status_q;
	assign out_class  = res_class_q;
	assign out_handle = res_handle_q;
	assign out_stamp  = res_stamp_q;

endmodule

/* rtl/tcaf_checker.sv */
// ----------------------------------------------------------------------------
// tcaf_checker
// Port-level checks for the two-class age-ordered FIFO, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_class_age_ordered_fifo_macros.svh"

module tcaf_checker import tcaf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic [1:0]              status,
	input logic                    out_class,
	input logic [HANDLE_WIDTH-1:0] out_handle,
	input logic [STAMP_WIDTH-1:0]  out_stamp
);

	// A stalled result must hold until its transfer.
	`TCAF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(out_class) && $stable(out_handle) && $stable(out_stamp), "result changed while stalled")

	// Reset clears the result valid at once.
	`TCAF_ASSERT_ALWAYS(a_rsp_reset, !arst_n |-> !rsp_valid, "result valid during reset")

	// An empty report carries no item.
	`TCAF_ASSERT(a_empty_zero, rsp_valid && (status == ST_EMPTY) |-> (out_handle == '0) && (out_stamp == '0), "empty status with nonzero item")

endmodule

bind two_class_age_ordered_fifo tcaf_checker u_tcaf_checker (.*);

/* tb/tcaf_result_checker.sv */
// ----------------------------------------------------------------------------
// tcaf_result_checker
// Watches the request and result channels of the two-class age-ordered FIFO.
// It keeps its own copy of both class queues and of the arrival stamp counter,
// works out the result of every request transfer, and compares each result
// transfer field by field with the oldest result still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcaf_result_checker import tcaf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic [1:0]              kind,
	input  logic                    item_class,
	input  logic [HANDLE_WIDTH-1:0] item_handle,
	input  logic                    rsp_valid,
	input  logic                    rsp_stall,
	input  logic [1:0]              status,
	input  logic                    out_class,
	input  logic [HANDLE_WIDTH-1:0] out_handle,
	input  logic [STAMP_WIDTH-1:0]  out_stamp,
	output int                      mismatches,
	output int                      awaited
);

	typedef struct {
		status_t                 status;
		logic                    cls;
		logic [HANDLE_WIDTH-1:0] handle;
		logic [STAMP_WIDTH-1:0]  stamp;
	} result_t;

	entry_t                 class_a_items[$];
	entry_t                 class_b_items[$];
	logic [STAMP_WIDTH-1:0] next_stamp = '0;
	result_t                awaited_results[$];

	// Applies one request to the local queues and returns the result it causes.
	function automatic result_t apply_request(kind_t k, logic c, logic [HANDLE_WIDTH-1:0] h);
		result_t                r;
		entry_t                 e;
		logic [STAMP_WIDTH-1:0] diff;
		logic                   take_b;
		r.status = ST_DONE;
		r.cls    = CLASS_A;
		r.handle = '0;
		r.stamp  = '0;
		if (k == KIND_ENQ) begin
			r.cls    = c;
			r.handle = h;
			r.stamp  = next_stamp;
			if (((c == CLASS_B) ? class_b_items.size() : class_a_items.size()) >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				e.handle = h;
				e.stamp  = next_stamp;
				if (c == CLASS_B)
					class_b_items.push_back(e);
				else
					class_a_items.push_back(e);
				next_stamp = next_stamp + 1'b1;
			end
		end else begin
			if (k == KIND_DEQ_ANY) begin
				// With both queues empty this falls to class A, which reports empty.
				if (class_b_items.size() == 0) begin
					take_b = 1'b0;
				end else if (class_a_items.size() == 0) begin
					take_b = 1'b1;
				end else begin
					diff   = class_a_items[0].stamp - class_b_items[0].stamp;
					take_b = !diff[STAMP_WIDTH-1];
				end
			end else begin
				take_b = (k == KIND_DEQ_B);
			end
			r.cls = take_b ? CLASS_B : CLASS_A;
			if (take_b ? (class_b_items.size() == 0) : (class_a_items.size() == 0)) begin
				r.status = ST_EMPTY;
			end else begin
				e        = take_b ? class_b_items.pop_front() : class_a_items.pop_front();
				r.handle = e.handle;
				r.stamp  = e.stamp;
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (expv !== actv) begin
			mismatches++;
			$error("%s: expected %0h, actual %0h", name, expv, actv);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t oldest;
		if (!arst_n) begin
			class_a_items.delete();
			class_b_items.delete();
			awaited_results.delete();
			next_stamp = '0;
			mismatches = 0;
			awaited    = 0;
		end else begin
			// Results are checked before new requests are taken, since a result
			// can never belong to a request transferred at the same edge.
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$error("result transfer with no result awaited");
				end else begin
					oldest = awaited_results.pop_front();
					check_field("status", 32'(oldest.status), 32'(status));
					check_field("out_class", 32'(oldest.cls), 32'(out_class));
					check_field("out_handle", 32'(oldest.handle), 32'(out_handle));
					check_field("out_stamp", 32'(oldest.stamp), 32'(out_stamp));
				end
			end
			if (req_valid && !req_stall)
				awaited_results.push_back(apply_request(kind_t'(kind), item_class, item_handle));
			awaited = awaited_results.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-class age-ordered FIFO. A directed opening
// covers empty and full queues and the age choice between classes, a short run
// of push/pop pairs follows, and random traffic then runs under several idle
// and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import tcaf_pkg::*; ();

	localparam int LONG_HOLD    = 300;
	localparam int PAIR_COUNT   = 40;
	localparam int PHASE_ITEMS  = 450;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_stall;
	logic [1:0]              kind;
	logic                    item_class;
	logic [HANDLE_WIDTH-1:0] item_handle;
	logic                    rsp_valid;
	logic                    rsp_stall;
	logic [1:0]              status;
	logic                    out_class;
	logic [HANDLE_WIDTH-1:0] out_handle;
	logic [STAMP_WIDTH-1:0]  out_stamp;
	int                      mismatches;
	int                      awaited;

	int idle_pct;
	int stall_pct;
	bit hold_off;

	two_class_age_ordered_fifo dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.item_class  (item_class),
		.item_handle (item_handle),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.out_class   (out_class),
		.out_handle  (out_handle),
		.out_stamp   (out_stamp)
	);

	tcaf_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.item_class  (item_class),
		.item_handle (item_handle),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.out_class   (out_class),
		.out_handle  (out_handle),
		.out_stamp   (out_stamp),
		.mismatches  (mismatches),
		.awaited     (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Result side: random stalls, or one long hold-off counted here.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_req(kind_t k, logic c, logic [HANDLE_WIDTH-1:0] h);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		kind        <= k;
		item_class  <= c;
		item_handle <= h;
		do @(posedge clk); while (req_stall);
	endtask

	// The awaited count is sampled away from the edge where the checker updates it.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		@(posedge clk);
	endtask

	task automatic run_random(int n);
		int enq_pct;
		enq_pct = 50;
		for (int i = 0; i < n; i++) begin
			// Stretches that lean toward filling or draining reach full and empty queues.
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: enq_pct = 50;
					1: enq_pct = 80;
					default: enq_pct = 20;
				endcase
			end
			if ($urandom_range(99) < enq_pct)
				send_req(KIND_ENQ, 1'($urandom_range(1)), HANDLE_WIDTH'($urandom()));
			else
				send_req(kind_t'($urandom_range(3, 1)), 1'($urandom_range(1)),
					HANDLE_WIDTH'($urandom()));
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		kind        <= KIND_ENQ;
		item_class  <= CLASS_A;
		item_handle <= '0;
		idle_pct    = 0;
		stall_pct   = 0;
		hold_off    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pops with everything empty.
		send_req(KIND_DEQ_ANY, CLASS_A, '0);
		send_req(KIND_DEQ_A, CLASS_B, 16'hFFFF);
		send_req(KIND_DEQ_B, CLASS_A, '0);
		// Interleaved pushes, then age order across classes; the last pop
		// finds class A empty and has to take class B.
		send_req(KIND_ENQ, CLASS_A, 16'h0000);
		send_req(KIND_ENQ, CLASS_B, 16'hFFFF);
		send_req(KIND_ENQ, CLASS_A, 16'h5555);
		send_req(KIND_ENQ, CLASS_B, 16'hAAAA);
		send_req(KIND_DEQ_ANY, CLASS_A, '0);
		send_req(KIND_DEQ_ANY, CLASS_A, '0);
		send_req(KIND_DEQ_A, CLASS_A, '0);
		send_req(KIND_DEQ_ANY, CLASS_A, '0);
		// Fill class A, push once more into the full queue, then pop with B empty.
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_req(KIND_ENQ, CLASS_A, HANDLE_WIDTH'($urandom()));
		send_req(KIND_DEQ_ANY, CLASS_B, 16'hFFFF);
		send_req(KIND_DEQ_B, CLASS_B, '0);

		// Empty both queues, then run push/pop pairs where each pop finds
		// exactly one item in one of the classes.
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			send_req(KIND_DEQ_A, CLASS_A, '0);
			send_req(KIND_DEQ_B, CLASS_B, '0);
		end
		for (int i = 0; i < PAIR_COUNT; i++) begin
			send_req(KIND_ENQ, 1'($urandom_range(1)), HANDLE_WIDTH'($urandom()));
			send_req(KIND_DEQ_ANY, CLASS_A, '0);
		end

		// No idling, with one long hold-off on the result side while requests keep coming.
		run_random(200);
		hold_off = 1'b1;
		run_random(PHASE_ITEMS - 200);

		idle_pct = 62;
		run_random(PHASE_ITEMS);
		wait_drained();

		idle_pct  = 0;
		stall_pct = 62;
		run_random(PHASE_ITEMS);

		idle_pct  = 22;
		stall_pct = 22;
		run_random(PHASE_ITEMS);

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/tcaf_pkg.sv
rtl/tcaf_queue.sv
rtl/two_class_age_ordered_fifo.sv
rtl/tcaf_checker.sv
tb/tcaf_result_checker.sv
tb/tb_top.sv
